// ===== rtl/sbm_pkg.sv =====
`timescale 1ns / 1ps
package sbm_pkg;
  localparam int SAMPLE_BITS = 24;
  localparam int DB_FLOOR_MAG = 25600;
  localparam logic [25:0] DB_PER_LOG2_Q16 = 26'd50504453;
  localparam int LOG_FRAC_BITS = 16;

  // Block totals handed from the accumulator to the level unit.
  typedef struct packed {
    logic [63:0] left_sum;
    logic [63:0] right_sum;
    logic [SAMPLE_BITS-1:0] left_peak;
    logic [SAMPLE_BITS-1:0] right_peak;
    logic [16:0] count;
  } sbm_block_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQUARE,
    ST_SCALE,
    ST_MULT,
    ST_DONE
  } sbm_state_t;
endpackage

// ===== rtl/stereo_block_peak_rms_meter.sv =====
`timescale 1ns / 1ps
// Samples are accumulated at one pair per cycle, unless stalled, in the front accumulator.
// A block-ending pair hands its totals to a register; the level unit then runs three log2
// passes (left sum, right sum, count) and scales each channel before the result is valid.
// The level unit takes a new block only after its last result is taken; samples
// stall only while a finished block waits and the level unit is busy.
// Synchronous active-high reset clears accumulators and sets two active channels.
module stereo_block_peak_rms_meter #(
  parameter int MAX_BLOCK_SAMPLES = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [23:0] left_sample,
  input  logic signed [23:0] right_sample,
  input  logic last_in_block,
  output logic out_valid,
  input  logic out_stall,
  output logic [23:0] left_peak,
  output logic [23:0] right_peak,
  output logic signed [15:0] left_rms_db,
  output logic signed [15:0] right_rms_db,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_data
);
  import sbm_pkg::*;
  logic [1:0] active_channels;
  logic blk_valid, blk_stall;
  sbm_block_t blk;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      active_channels <= cfg_data;
    end
  end

  sbm_front #(.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .left_in(left_sample), .right_in(right_sample), .last_in(last_in_block),
    .blk_valid, .blk_stall, .blk
  );

  sbm_level u_level (
    .clk, .rst, .blk_valid, .blk_stall, .blk, .active_channels,
    .out_valid, .out_stall, .left_peak, .right_peak, .left_rms_db, .right_rms_db
  );
endmodule

// ===== rtl/sbm_front.sv =====
`timescale 1ns / 1ps
module sbm_front #(
  parameter int MAX_BLOCK_SAMPLES = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [sbm_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic [sbm_pkg::SAMPLE_BITS-1:0] right_in,
  input  logic last_in,
  output logic blk_valid,
  input  logic blk_stall,
  output sbm_pkg::sbm_block_t blk
);
  import sbm_pkg::*;
  localparam int CW = 17;
  localparam int SQW = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] peak [2];
  logic [63:0] sum [2];
  logic [CW-1:0] count;
  logic [SAMPLE_BITS-1:0] mag [2];
  logic [SQW-1:0] sq [2];
  logic [CW-1:0] count_next;
  logic fire, ends;
  logic [SAMPLE_BITS-1:0] raw [2];

  assign raw[0] = left_in;
  assign raw[1] = right_in;
  // A pending block waits in the output register; samples stall only then.
  assign in_stall = blk_valid && blk_stall;
  assign fire = in_valid && !in_stall;
  assign count_next = count + 1'b1;
  assign ends = last_in || (count_next >= CW'(MAX_BLOCK_SAMPLES));

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      mag[c] = raw[c][SAMPLE_BITS-1] ? (~raw[c] + 1'b1) : raw[c];
      sq[c] = SQW'(mag[c]) * SQW'(mag[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      count <= '0;
      for (int c = 0; c < 2; c++) begin
        peak[c] <= '0;
        sum[c] <= '0;
      end
    end else begin
      blk_valid <= (fire && ends) || (blk_valid && blk_stall);
      if (fire) begin
        if (ends) begin
          blk.left_peak <= (mag[0] > peak[0]) ? mag[0] : peak[0];
          blk.right_peak <= (mag[1] > peak[1]) ? mag[1] : peak[1];
          blk.left_sum <= sum[0] + 64'(sq[0]);
          blk.right_sum <= sum[1] + 64'(sq[1]);
          blk.count <= count_next;
          count <= '0;
          for (int c = 0; c < 2; c++) begin
            peak[c] <= '0;
            sum[c] <= '0;
          end
        end else begin
          count <= count_next;
          for (int c = 0; c < 2; c++) begin
            if (mag[c] > peak[c]) peak[c] <= mag[c];
            sum[c] <= sum[c] + 64'(sq[c]);
          end
        end
      end
    end
  end
endmodule

// ===== rtl/sbm_level.sv =====
`timescale 1ns / 1ps
module sbm_level (
  input  logic clk,
  input  logic rst,
  input  logic blk_valid,
  output logic blk_stall,
  input  sbm_pkg::sbm_block_t blk,
  input  logic [1:0] active_channels,
  output logic out_valid,
  input  logic out_stall,
  output logic [23:0] left_peak,
  output logic [23:0] right_peak,
  output logic [15:0] left_rms_db,
  output logic [15:0] right_rms_db
);
  import sbm_pkg::*;

  sbm_state_t state, state_next;
  sbm_block_t b;
  logic [1:0] job;       // 0 left sum, 1 right sum, 2 count
  logic [4:0] step;
  logic [63:0] v;
  logic [5:0] e;
  logic [31:0] y;
  logic [15:0] frac;
  logic [21:0] lg [3];
  logic signed [24:0] lval;
  logic [57:0] prod;
  logic [15:0] db [2];
  logic ch;
  logic [5:0] hi;
  logic [63:0] ysq;
  logic [31:0] ysq30;
  logic signed [24:0] l_comb;
  logic [24:0] lmag;

  assign blk_stall = (state != ST_IDLE);

  always_comb begin
    hi = '0;
    for (int i = 1; i < 64; i++) if (v[i]) hi = 6'(i);
    ysq = 64'(y) * 64'(y);
    ysq30 = ysq[61:30];
    l_comb = 25'(signed'({3'b0, lg[{1'b0, ch}]})) - 25'(signed'({3'b0, lg[2]}))
           - 25'(2 * (SAMPLE_BITS - 1) * 65536);
    lmag = 25'(-lval);
    prod = 58'(lmag) * 58'(DB_PER_LOG2_Q16) + 58'(64'd1 << 31);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (blk_valid) state_next = ST_NORM;
      ST_NORM: state_next = ST_SQUARE;
      ST_SQUARE: if (step == 5'd15) state_next = (job == 2'd2) ? ST_SCALE : ST_NORM;
      ST_SCALE: state_next = ST_MULT;
      ST_MULT: state_next = ch ? ST_DONE : ST_SCALE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      ST_IDLE: begin
        b <= blk;
        job <= '0;
        v <= blk.left_sum;
        ch <= 1'b0;
      end
      ST_NORM: begin
        e <= hi;
        y <= (hi >= 6'd30) ? 32'(v >> (hi - 6'd30)) : 32'(v << (6'd30 - hi));
        frac <= '0;
        step <= '0;
      end
      ST_SQUARE: begin
        step <= step + 1'b1;
        if (ysq30[31]) begin
          y <= ysq30 >> 1;
          frac <= {frac[14:0], 1'b1};
        end else begin
          y <= ysq30;
          frac <= {frac[14:0], 1'b0};
        end
        if (step == 5'd15) begin
          lg[job] <= {e, frac[14:0], ysq30[31]};
          job <= job + 1'b1;
          v <= (job == 2'd0) ? b.right_sum : 64'(b.count);
        end
      end
      ST_SCALE: begin
        lval <= l_comb;
      end
      ST_MULT: begin
        ch <= 1'b1;
        if ({1'b0, ch} >= active_channels || (ch ? b.right_sum : b.left_sum) == '0)
          db[ch] <= 16'(-DB_FLOOR_MAG);
        else if (!lval[24])
          db[ch] <= '0;
        else
          db[ch] <= (prod[57:32] > 26'(DB_FLOOR_MAG)) ? 16'(-DB_FLOOR_MAG)
                                                      : 16'(-prod[47:32]);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign left_peak = (active_channels >= 2'd1) ? b.left_peak : '0;
  assign right_peak = (active_channels >= 2'd2) ? b.right_peak : '0;
  assign left_rms_db = db[0];
  assign right_rms_db = db[1];
endmodule

// ===== rtl/sbm_checker.sv =====
`timescale 1ns / 1ps
module sbm_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic signed [15:0] left_rms_db,
  input logic signed [15:0] right_rms_db
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_left: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_rms_db <= 0 && left_rms_db >= -16'sd25600) else $error("left db");
  a_right: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> right_rms_db <= 0 && right_rms_db >= -16'sd25600) else $error("right db");
endmodule

bind stereo_block_peak_rms_meter sbm_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .left_rms_db, .right_rms_db
);

// ===== verif/sbm_checker.sv =====
`timescale 1ns / 1ps
module sbm_scoreboard (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic signed [23:0] left_sample,
  input  logic signed [23:0] right_sample,
  input  logic last_in_block,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [23:0] left_peak,
  input  logic [23:0] right_peak,
  input  logic signed [15:0] left_rms_db,
  input  logic signed [15:0] right_rms_db,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [1:0] cfg_data,
  output int fail_count,
  output int levels_pending,
  output logic progress
);
  localparam int BLOCK_LIMIT = 4096;
  localparam int FULL_SCALE_LOG2_Q16 = 46 * 65536;
  localparam longint DB_SCALE_Q16 = 64'd50504453;

  typedef struct packed {
    logic [23:0] lpk;
    logic [23:0] rpk;
    logic signed [15:0] ldb;
    logic signed [15:0] rdb;
  } level_t;

  level_t level_queue[$];
  logic [23:0] peak_acc[2];
  logic [63:0] energy_acc[2];
  int block_len;
  logic [1:0] channels_on;

  function automatic longint log2_fixed(logic [63:0] v);
    int e;
    logic [63:0] y;
    longint frac;
    e = 63;
    frac = 0;
    while (e > 0 && v[e] == 1'b0) e--;
    if (e >= 30) y = v >> (e - 30);
    else y = v << (30 - e);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic logic signed [15:0] rms_level(logic [63:0] energy, int n);
    longint l;
    logic [63:0] mag;
    if (energy == 0 || n == 0) return -16'sd25600;
    l = log2_fixed(energy) - log2_fixed(64'(n)) - FULL_SCALE_LOG2_Q16;
    if (l >= 0) return 16'sd0;
    mag = (64'(-l) * DB_SCALE_Q16 + (64'd1 << 31)) >> 32;
    if (mag > 25600) mag = 25600;
    return -16'(mag);
  endfunction

  function automatic logic [23:0] magnitude(logic signed [23:0] s);
    return s[23] ? 24'(-s) : 24'(s);
  endfunction

  assign levels_pending = level_queue.size();

  always_ff @(posedge clk) begin
    level_t lv, got;
    logic [23:0] a;
    logic moved;
    moved = 1'b0;
    if (rst) begin
      peak_acc[0] <= '0;
      peak_acc[1] <= '0;
      energy_acc[0] <= '0;
      energy_acc[1] <= '0;
      block_len <= 0;
      channels_on <= 2'd2;
      fail_count <= 0;
      level_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        channels_on <= cfg_data;
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        logic [23:0] pk[2];
        logic [63:0] en[2];
        moved = 1'b1;
        for (int c = 0; c < 2; c++) begin
          a = magnitude(c == 0 ? left_sample : right_sample);
          pk[c] = (a > peak_acc[c]) ? a : peak_acc[c];
          en[c] = energy_acc[c] + 64'(a) * 64'(a);
        end
        if (last_in_block || block_len + 1 >= BLOCK_LIMIT) begin
          // The setting in force at the block end picks the reported channels.
          lv.lpk = (channels_on >= 1) ? pk[0] : 24'd0;
          lv.rpk = (channels_on >= 2) ? pk[1] : 24'd0;
          lv.ldb = (channels_on >= 1) ? rms_level(en[0], block_len + 1) : -16'sd25600;
          lv.rdb = (channels_on >= 2) ? rms_level(en[1], block_len + 1) : -16'sd25600;
          level_queue.push_back(lv);
          peak_acc[0] <= '0;
          peak_acc[1] <= '0;
          energy_acc[0] <= '0;
          energy_acc[1] <= '0;
          block_len <= 0;
        end else begin
          peak_acc[0] <= pk[0];
          peak_acc[1] <= pk[1];
          energy_acc[0] <= en[0];
          energy_acc[1] <= en[1];
          block_len <= block_len + 1;
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (level_queue.size() == 0) begin
          $error("unexpected level transfer");
          fail_count <= fail_count + 1;
        end else begin
          got = level_queue.pop_front();
          if (got.lpk !== left_peak || got.rpk !== right_peak ||
              got.ldb !== left_rms_db || got.rdb !== right_rms_db) begin
            fail_count <= fail_count + 1;
            if (got.lpk !== left_peak)
              $error("left_peak expected %0d actual %0d", got.lpk, left_peak);
            if (got.rpk !== right_peak)
              $error("right_peak expected %0d actual %0d", got.rpk, right_peak);
            if (got.ldb !== left_rms_db)
              $error("left_rms_db expected %0d actual %0d", got.ldb, left_rms_db);
            if (got.rdb !== right_rms_db)
              $error("right_rms_db expected %0d actual %0d", got.rdb, right_rms_db);
          end
        end
      end
    end
    progress <= moved;
  end
endmodule

// ===== verif/tb_stereo_block_peak_rms_meter.sv =====
`timescale 1ns / 1ps
module tb_stereo_block_peak_rms_meter;
  localparam int QUIET_LIMIT = 20000;

  logic clk, rst;
  logic in_valid, in_stall, last_in_block;
  logic signed [23:0] left_sample, right_sample;
  logic out_valid, out_stall;
  logic [23:0] left_peak, right_peak;
  logic signed [15:0] left_rms_db, right_rms_db;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_data;
  int fail_count, levels_pending;
  logic progress;
  bit busy_free;
  int quiet_cycles;

  stereo_block_peak_rms_meter u_dut (.*);

  sbm_scoreboard u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random receiver stall, except during a calm stretch.
  always @(negedge clk) out_stall <= busy_free ? 1'b0 : ($urandom_range(99) < 38);

  always @(posedge clk) begin
    if (rst || progress) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Leaves valid high so that the next pair can follow without a gap.
  task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r, logic last);
    while (!busy_free && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    left_sample <= l;
    right_sample <= r;
    last_in_block <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_channels(logic [1:0] n);
    in_valid <= 1'b0;
    while (levels_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return 24'(signed'($urandom_range(15)) - 8);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_blocks(int pairs);
    int len;
    while (pairs > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64) + 1 : $urandom_range(12) + 1;
      for (int i = 0; i < len; i++)
        send_pair(rand_sample(), rand_sample(), i == len - 1);
      pairs -= len;
    end
  endtask

  initial begin
    in_valid = 1'b0;
    left_sample = '0;
    right_sample = '0;
    last_in_block = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 2'd2;
    out_stall = 1'b0;
    busy_free = 1'b0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, silence, single-pair blocks, a mixed block.
    send_pair(24'sh800000, 24'sh7fffff, 1'b1);
    send_pair(24'sh000000, 24'sh000000, 1'b1);
    send_pair(24'sh000001, -24'sh000001, 1'b1);
    send_pair(24'sh7fffff, 24'sh000000, 1'b0);
    send_pair(-24'sh400000, 24'sh555555, 1'b0);
    send_pair(24'sh2aaaaa, 24'shffffff, 1'b1);
    // The register changes between blocks; the value at the block end decides.
    write_channels(2'd1);
    send_pair(24'sh123456, 24'sh654321, 1'b1);
    write_channels(2'd0);
    send_pair(24'sh800000, 24'sh800000, 1'b1);
    write_channels(2'd3);
    send_pair(24'sh0abcde, -24'sh0abcde, 1'b1);
    write_channels(2'd2);

    random_blocks(400);
    write_channels(2'd1);
    random_blocks(200);
    write_channels(2'd0);
    random_blocks(100);
    write_channels(2'd3);
    busy_free = 1'b1;
    random_blocks(200);
    busy_free = 1'b0;
    write_channels(2'd2);
    random_blocks(350);
    in_valid <= 1'b0;

    while (levels_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
